// ----- hdl/ltc_pkg.sv -----
// shared types, constants and keyword tables for the lexical token classifier
package ltc_pkg;

  localparam int NUMBER_BITS     = 32;
  localparam int LINE_COUNT_BITS = 16;
  localparam int KW_COUNT        = 11;
  localparam int KW_CHARS        = 7;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW         = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] KW_INT    = 4'd4;
  localparam logic [3:0] KW_DOUBLE = 4'd7;
  localparam logic [3:0] NO_KW     = 4'd11;

  localparam logic [KW_COUNT-1:0]        ALL_CAND  = '1;
  localparam logic [NUMBER_BITS-1:0]     NUM_MAX   = '1;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX  = '1;
  localparam logic [7:0]                 LEN_MAX   = 8'hFF;

  // keyword text, left aligned and zero padded to KW_CHARS bytes
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    {"main",   24'h0}, {"for",    32'h0}, {"while",  16'h0}, {"do",     40'h0},
    {"int",    32'h0}, {"float",  16'h0}, {"char",   24'h0}, {"double",  8'h0},
    {"static",  8'h0}, {"switch",  8'h0}, {"case",   24'h0}
  };

  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd4, 8'd3, 8'd5, 8'd2, 8'd3, 8'd5, 8'd4, 8'd6, 8'd6, 8'd6, 8'd4
  };

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT
  } scan_mode_t;

  typedef enum logic [2:0] {
    TK_NUMBER,
    TK_KEYWORD,
    TK_IDENT,
    TK_ARITH,
    TK_LOGIC,
    TK_SPECIAL,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    tok_kind_t                  token_kind;
    logic [NUMBER_BITS-1:0]     number_value;
    logic [3:0]                 keyword_index;
    logic                       is_datatype;
    logic [7:0]                 ident_length;
    logic [7:0]                 special_char;
    logic [LINE_COUNT_BITS-1:0] line_count;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic [1:0] npush;
    result_t    res0;
    result_t    res1;
  } push_t;

  typedef struct packed {
    scan_mode_t                 mode;
    logic [LINE_COUNT_BITS-1:0] line;
  } scan_stat_t;

  typedef struct packed {
    logic               room;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  // character of keyword idx at position pos, zero past the text
  function automatic logic [7:0] kw_char(input int idx, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (int'(pos) < KW_CHARS) begin
      c = KW_TEXT[idx][(KW_CHARS - 1 - int'(pos)) * 8 +: 8];
    end
    return c;
  endfunction

endpackage

// ----- hdl/ltc_chan_if.sv -----
// valid/ready channel interfaces for source bytes and tokens
interface ltc_in_if import ltc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface ltc_out_if import ltc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  tok_kind_t                  token_kind;
  logic [NUMBER_BITS-1:0]     number_value;
  logic [3:0]                 keyword_index;
  logic                       is_datatype;
  logic [7:0]                 ident_length;
  logic [7:0]                 special_char;
  logic [LINE_COUNT_BITS-1:0] line_count;
  logic                       last;

  modport source (output valid, output token_kind, output number_value,
                  output keyword_index, output is_datatype, output ident_length,
                  output special_char, output line_count, output last, input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input keyword_index, input is_datatype, input ident_length,
                  input special_char, input line_count, input last, output ready);
endinterface

// ----- hdl/ltc_scan.sv -----
// scanner state and per-byte classification, up to two tokens per byte
module ltc_scan import ltc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  item_t      item,
  output push_t      push,
  output scan_stat_t stat
);

  scan_mode_t                 mode_r, mode_nxt;
  logic [NUMBER_BITS-1:0]     acc_r, acc_nxt;
  logic [KW_COUNT-1:0]        cand_r, cand_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;

  logic [7:0] b;
  logic       eoi, dig, alph, idc, ws, nl;
  logic       cont_num, cont_id, has_flush, has_second;
  logic [NUMBER_BITS+3:0] acc_wide;
  logic [NUMBER_BITS-1:0] acc_base, acc_calc;
  logic [7:0]             len_base, len_calc;
  logic [KW_COUNT-1:0]    cand_base, cand_calc;
  logic [3:0]             hit;
  result_t                flush_res, second_res;

  assign b    = item.data_byte;
  assign eoi  = item.end_of_input;
  assign dig  = (b >= "0") && (b <= "9");
  assign alph = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  assign idc  = alph || dig || (b == "_") || (b == "$");
  assign ws   = (b == " ") || (b == 8'h09);
  assign nl   = (b == 8'h0A);

  assign cont_num  = !eoi && (mode_r == MODE_NUM) && dig;
  assign cont_id   = !eoi && (mode_r == MODE_IDENT) && idc;
  assign has_flush = (mode_r != MODE_IDLE) && !cont_num && !cont_id;
  assign has_second = eoi || (!cont_num && !cont_id && !dig && !alph && !ws && !nl);

  // next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (go) begin
      if (eoi) begin
        mode_nxt = MODE_IDLE;
      end else if (cont_num || cont_id) begin
        mode_nxt = mode_r;
      end else if (dig) begin
        mode_nxt = MODE_NUM;
      end else if (alph) begin
        mode_nxt = MODE_IDENT;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end
  end

  // digit accumulation: acc*10 + digit, saturating
  always_comb begin
    acc_base = cont_num ? acc_r : '0;
    acc_wide = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
             + (NUMBER_BITS+4)'(b[3:0]);
    acc_calc = (acc_wide[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ? NUM_MAX
             : acc_wide[NUMBER_BITS-1:0];
  end

  // keyword candidate narrowing, one character per byte
  always_comb begin
    len_base  = cont_id ? len_r : 8'd0;
    cand_base = cont_id ? cand_r : ALL_CAND;
    for (int i = 0; i < KW_COUNT; i++) begin
      cand_calc[i] = cand_base[i] && (len_base < KW_LEN[i])
                  && (kw_char(i, len_base[2:0]) == b);
    end
    len_calc = (len_base == LEN_MAX) ? LEN_MAX : len_base + 8'd1;
  end

  // first surviving keyword whose length matches
  always_comb begin
    hit = NO_KW;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (cand_r[i] && (KW_LEN[i] == len_r)) begin
        hit = 4'(i);
      end
    end
  end

  // token outputs
  always_comb begin
    flush_res = '0;
    flush_res.keyword_index = NO_KW;
    flush_res.line_count    = line_r;
    flush_res.last          = !has_second;
    unique case (mode_r)
      MODE_NUM: begin
        flush_res.token_kind   = TK_NUMBER;
        flush_res.number_value = acc_r;
      end
      MODE_IDENT: begin
        flush_res.token_kind    = (hit != NO_KW) ? TK_KEYWORD : TK_IDENT;
        flush_res.keyword_index = hit;
        flush_res.is_datatype   = (hit >= KW_INT) && (hit <= KW_DOUBLE);
        flush_res.ident_length  = len_r;
      end
      default: begin
        flush_res.token_kind = TK_END;
      end
    endcase

    second_res = '0;
    second_res.keyword_index = NO_KW;
    second_res.line_count    = line_r;
    second_res.last          = 1'b1;
    if (eoi) begin
      second_res.token_kind = TK_END;
    end else begin
      second_res.special_char = b;
      case (b) inside
        "+", "-", "*", "/", "%": second_res.token_kind = TK_ARITH;
        "&", "|", "!":           second_res.token_kind = TK_LOGIC;
        default:                 second_res.token_kind = TK_SPECIAL;
      endcase
    end

    push.npush = go ? (2'(has_flush) + 2'(has_second)) : 2'd0;
    push.res0  = has_flush ? flush_res : second_res;
    push.res1  = second_res;
  end

  // token state and line count updates
  always_comb begin
    acc_nxt  = acc_r;
    cand_nxt = cand_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    if (go) begin
      acc_nxt  = (mode_nxt == MODE_NUM) ? acc_calc : '0;
      cand_nxt = (mode_nxt == MODE_IDENT) ? cand_calc : ALL_CAND;
      len_nxt  = (mode_nxt == MODE_IDENT) ? len_calc : 8'd0;
      if (!eoi && nl && (line_r != LINE_MAX)) begin
        line_nxt = line_r + LINE_COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cand_r <= ALL_CAND;
      len_r  <= 8'd0;
      line_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cand_r <= cand_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
    end
  end

  assign stat.mode = mode_r;
  assign stat.line = line_r;

endmodule

// ----- hdl/ltc_res_fifo.sv -----
// token queue: takes up to two tokens per cycle, hands out one per cycle while out_ch is ready
module ltc_res_fifo import ltc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  output fifo_stat_t       stat,
  ltc_out_if.source        out_ch
);

  result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pop;
  result_t            head;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push.npush);
    rd_nxt    = rd_r + FIFO_AW'(pop);
    count_nxt = count_r + FIFO_CW'(push.npush) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.npush != 2'd0) begin
      mem_r[wr_r] <= push.res0;
    end
    if (push.npush == 2'd2) begin
      mem_r[wr_r + FIFO_AW'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // room for the worst case of two tokens from one byte
  assign stat.room  = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign stat.count = count_r;

  assign head                 = mem_r[rd_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.token_kind    = head.token_kind;
  assign out_ch.number_value  = head.number_value;
  assign out_ch.keyword_index = head.keyword_index;
  assign out_ch.is_datatype   = head.is_datatype;
  assign out_ch.ident_length  = head.ident_length;
  assign out_ch.special_char  = head.special_char;
  assign out_ch.line_count    = head.line_count;
  assign out_ch.last          = head.last;

endmodule

// ----- hdl/c_lexical_token_classifier.sv -----
// top level of the streaming lexical token classifier
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    data_byte, end_of_input
//   out_ch   out  valid/ready    token_kind, number_value, keyword_index, is_datatype,
//                                ident_length, special_char, line_count, last
//
// with queue room, one byte per cycle: the input register holds a request while the
// scanner classifies it and writes its zero, one or two tokens into a four-entry queue
// tokens leave one per cycle while out_ch is ready, also in a burst of two-token bytes
// the input stalls only when the queue holds more than two tokens
// synchronous active-low reset empties both stages and returns the scanner to idle
module c_lexical_token_classifier import ltc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ltc_in_if.sink    in_ch,
  ltc_out_if.source out_ch
);

  logic       in_valid_r, in_valid_nxt;
  item_t      item_r;
  logic       go, accept;
  push_t      push;
  scan_stat_t sstat;
  fifo_stat_t fstat;

  assign go          = in_valid_r && fstat.room;
  assign in_ch.ready = !in_valid_r || go;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte    <= in_ch.data_byte;
      item_r.end_of_input <= in_ch.end_of_input;
    end
  end

  ltc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .push  (push),
    .stat  (sstat)
  );

  ltc_res_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .stat   (fstat),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("token queue overfilled");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go && item_r.end_of_input |=> sstat.mode == MODE_IDLE)
    else $error("scanner not idle after end of input");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.npush == 2'd2 |-> !push.res0.last && push.res1.last)
    else $error("last flag wrong on a token pair");

  a_line_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sstat.line >= $past(sstat.line))
    else $error("line count went backwards");
`endif

endmodule
